// ===== rtl/rncv_pkg.sv =====
package rncv_pkg;

   localparam int SENSOR_BITS_DEFAULT = 16;
   localparam int VOTE_BITS_DEFAULT   = 16;
   localparam int NUM_CLASSES         = 3;
   localparam int SCALE_MAX           = 255;
   localparam int CSR_IDX_BITS        = 3;
   localparam int CSR_DATA_BITS       = 36;
   localparam int CEN_BITS            = 12;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_RED_RANGE   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_GREEN_RANGE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_BLUE_RANGE  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BG_CEN      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_BLUE_CEN    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_YELLOW_CEN  = 3'd5;

   // class codes
   localparam logic [1:0] CLS_BACKGROUND = 2'd0;
   localparam logic [1:0] CLS_BLUE       = 2'd1;
   localparam logic [1:0] CLS_YELLOW     = 2'd2;

   // lane control
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } lane_ctl_type;

endpackage

// ===== rtl/rncv_lane.sv =====
// one color channel: restoring divide of (x-lo)*255 by (hi-lo), then clamp
module rncv_lane
   import rncv_pkg::*;
#(
   parameter int SENSOR_BITS = SENSOR_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SENSOR_BITS-1:0] raw,
   input  logic [SENSOR_BITS-1:0] lo,
   input  logic [SENSOR_BITS-1:0] hi,
   output lane_ctl_type           ctl,
   output logic [7:0]             scaled
);

   // magnitude of the dividend fits SENSOR_BITS + 8 bits
   localparam int NB = SENSOR_BITS + 8;
   localparam int CB = $clog2(NB + 1);

   logic [NB-1:0]           quo_ff, quo_in;
   logic [SENSOR_BITS:0]    rem_ff, rem_in;
   logic [SENSOR_BITS-1:0]  den_ff, den_in;
   logic [NB-1:0]           num_ff, num_in;
   logic                    neg_ff, neg_in;
   logic                    zero_ff, zero_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CB-1:0]           cnt_ff, cnt_in;
   logic [7:0]              res_ff, res_in;

   logic signed [SENSOR_BITS:0] dx, dd;
   logic [NB-1:0]               prod;
   logic [SENSOR_BITS+1:0]      trial;
   logic [NB-1:0]               qn;

   always_comb begin
      dx   = $signed({1'b0, raw}) - $signed({1'b0, lo});
      dd   = $signed({1'b0, hi}) - $signed({1'b0, lo});
      prod = NB'(dx[SENSOR_BITS] ? -dx : dx) * NB'(SCALE_MAX);
      trial = {rem_ff, num_ff[NB-1]} - {2'b00, den_ff};
      qn    = {quo_ff[NB-2:0], ~trial[SENSOR_BITS+1]};
   end

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff; num_in = num_ff;
      neg_in = neg_ff; zero_in = zero_ff; busy_in = busy_ff; done_in = 1'b0;
      cnt_in = cnt_ff; res_in = res_ff;
      if (start) begin
         // load operands, sign of quotient kept aside
         num_in  = prod;
         den_in  = SENSOR_BITS'(dd[SENSOR_BITS] ? -dd : dd);
         neg_in  = (dx[SENSOR_BITS] ^ dd[SENSOR_BITS]) && (dx != '0);
         zero_in = (dd == '0);
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CB'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in = trial[SENSOR_BITS+1] ? {rem_ff[SENSOR_BITS-1:0], num_ff[NB-1]}
                                        : trial[SENSOR_BITS:0];
         num_in = {num_ff[NB-2:0], 1'b0};
         quo_in = qn;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (zero_ff || neg_ff || qn == '0) res_in = 8'd0;
            else if (qn > NB'(SCALE_MAX))      res_in = 8'(SCALE_MAX);
            else                               res_in = qn[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; num_ff <= num_in;
      neg_ff <= neg_in; zero_ff <= zero_in; cnt_ff <= cnt_in; res_ff <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl    = '{start: start, busy: busy_ff, done: done_ff};
   assign scaled = res_ff;

endmodule

// ===== rtl/rncv_merge.sv =====
// distance to each centroid, nearest class, vote and window decision
module rncv_merge
   import rncv_pkg::*;
#(
   parameter int VOTE_BITS = VOTE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  window_end,
   input  logic [7:0]            px_r,
   input  logic [7:0]            px_g,
   input  logic [7:0]            px_b,
   input  logic [3*CEN_BITS-1:0] cen0,
   input  logic [3*CEN_BITS-1:0] cen1,
   input  logic [3*CEN_BITS-1:0] cen2,
   output logic                  done,
   output logic [1:0]            sample_class,
   output logic [1:0]            winner
);

   localparam int DB = 2 * (CEN_BITS + 1) + 2;

   // state codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_VOTE = 2'd1;

   logic [1:0]           st_ff, st_in;
   logic [DB-1:0]        dist_ff [NUM_CLASSES];
   logic [DB-1:0]        dist_in [NUM_CLASSES];
   logic [VOTE_BITS-1:0] vote_ff [NUM_CLASSES];
   logic [VOTE_BITS-1:0] vote_in [NUM_CLASSES];
   logic [1:0]           cls_ff, cls_in, win_ff, win_in;
   logic                 done_ff, done_in;
   logic [1:0]           cls_c;
   logic [1:0]           w_c;
   logic [VOTE_BITS-1:0] vt [NUM_CLASSES];

   function automatic logic [DB-1:0] sqd(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b,
                                        input logic [3*CEN_BITS-1:0] c);
      logic signed [CEN_BITS:0] d0, d1, d2;
      logic signed [DB-1:0]     e0, e1, e2;
      d0 = $signed({1'b0, r, 4'h0}) - $signed({1'b0, c[11:0]});
      d1 = $signed({1'b0, g, 4'h0}) - $signed({1'b0, c[23:12]});
      d2 = $signed({1'b0, b, 4'h0}) - $signed({1'b0, c[35:24]});
      // widen before squaring
      e0 = DB'(d0);
      e1 = DB'(d1);
      e2 = DB'(d2);
      return DB'(e0 * e0 + e1 * e1 + e2 * e2);
   endfunction

   always_comb begin
      // nearest class, ties to the lower index
      cls_c = CLS_BACKGROUND;
      if (dist_ff[1] < dist_ff[0]) cls_c = CLS_BLUE;
      if (dist_ff[2] < ((cls_c == CLS_BLUE) ? dist_ff[1] : dist_ff[0])) cls_c = CLS_YELLOW;
      for (int i = 0; i < NUM_CLASSES; i++)
         vt[i] = (2'(i) == cls_c && vote_ff[i] != '1) ? vote_ff[i] + 1'b1 : vote_ff[i];
      w_c = CLS_BACKGROUND;
      if (vt[1] > vt[0]) w_c = CLS_BLUE;
      if (vt[2] > ((w_c == CLS_BLUE) ? vt[1] : vt[0])) w_c = CLS_YELLOW;
   end

   always_comb begin
      st_in = st_ff; dist_in = dist_ff; vote_in = vote_ff;
      cls_in = cls_ff; win_in = win_ff; done_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               dist_in[0] = sqd(px_r, px_g, px_b, cen0);
               dist_in[1] = sqd(px_r, px_g, px_b, cen1);
               dist_in[2] = sqd(px_r, px_g, px_b, cen2);
               st_in = ST_VOTE;
            end
         end
         ST_VOTE: begin
            cls_in  = cls_c;
            win_in  = window_end ? w_c : CLS_BACKGROUND;
            for (int i = 0; i < NUM_CLASSES; i++)
               vote_in[i] = window_end ? '0 : vt[i];
            done_in = 1'b1;
            st_in   = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in; cls_ff <= cls_in; win_ff <= win_in;
      if (reset) begin
         st_ff   <= ST_IDLE;
         done_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) vote_ff[i] <= '0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
         vote_ff <= vote_in;
      end
   end

   assign done         = done_ff;
   assign sample_class = cls_ff;
   assign winner       = win_ff;

endmodule

// ===== rtl/rgb_nearest_centroid_vote_core.sv =====
// an accepted item passes through the bit-serial divider in each of the three channel lanes,
// then the merge distance and vote states, before the result is registered for output
// no new item is accepted until the previous result has been taken,
// so a result waiting on rsp_tready holds off the next item
// reset: synchronous active high; ranges to min 0 max 65535, centroids and votes to 0
module rgb_nearest_centroid_vote_core
   import rncv_pkg::*;
#(
   parameter int SENSOR_BITS = SENSOR_BITS_DEFAULT,
   parameter int VOTE_BITS   = VOTE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // raw_red, raw_green, raw_blue
   input  logic [3*SENSOR_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // scaled_red, scaled_green, scaled_blue, sample_class, winner, zero pad
   output logic [31:0]              rsp_tdata,
   output logic                     rsp_tlast,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int SB = SENSOR_BITS;

   logic [31:0]              rng_ff [3];
   logic [3*CEN_BITS-1:0]    cen_ff [NUM_CLASSES];
   logic                     busy_ff, busy_in, last_ff, full_ff, full_in;
   logic [31:0]              out_ff;
   logic                     olast_ff;
   logic                     acc;
   lane_ctl_type             ctl [3];
   logic [7:0]               sc [3];
   logic                     m_done;
   logic [1:0]               m_cls, m_win;

   assign acc        = req_tvalid && req_tready;
   assign req_tready = !busy_ff;
   assign csr_ready  = 1'b1;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) rng_ff[i] <= 32'hFFFF0000;
         for (int i = 0; i < NUM_CLASSES; i++) cen_ff[i] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_RED_RANGE:   rng_ff[0] <= csr_data[31:0];
            REG_GREEN_RANGE: rng_ff[1] <= csr_data[31:0];
            REG_BLUE_RANGE:  rng_ff[2] <= csr_data[31:0];
            REG_BG_CEN:      cen_ff[0] <= csr_data;
            REG_BLUE_CEN:    cen_ff[1] <= csr_data;
            REG_YELLOW_CEN:  cen_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // channel lanes, range bounds held in 16-bit halves
   for (genvar g = 0; g < 3; g++) begin : g_lane
      rncv_lane #(.SENSOR_BITS(SB)) u_lane (
         .clock(clock), .reset(reset), .start(acc),
         .raw(req_tdata[g*SB +: SB]),
         .lo(SB'(rng_ff[g][15:0])),
         .hi(SB'(rng_ff[g][31:16])),
         .ctl(ctl[g]), .scaled(sc[g])
      );
   end

   rncv_merge #(.VOTE_BITS(VOTE_BITS)) u_merge (
      .clock(clock), .reset(reset), .start(ctl[0].done), .window_end(last_ff),
      .px_r(sc[0]), .px_g(sc[1]), .px_b(sc[2]),
      .cen0(cen_ff[0]), .cen1(cen_ff[1]), .cen2(cen_ff[2]),
      .done(m_done), .sample_class(m_cls), .winner(m_win)
   );

   // busy from accept until the result is taken
   always_comb begin
      busy_in = busy_ff;
      full_in = full_ff;
      if (acc) busy_in = 1'b1;
      if (m_done) full_in = 1'b1;
      if (full_ff && rsp_tready) begin
         full_in = 1'b0;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) last_ff <= req_tlast;
      if (m_done) begin
         out_ff   <= {4'd0, m_win, m_cls, sc[2], sc[1], sc[0]};
         olast_ff <= last_ff;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         full_ff <= full_in;
      end
   end

   assign rsp_tvalid = full_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = olast_ff;

   assert property (@(posedge clock) disable iff (reset) acc |=> !req_tready);
   assert property (@(posedge clock) disable iff (reset) m_done |-> busy_ff && !full_ff)
      else $error("result without pending item");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule
